// ===== sv/sdtq_pkg.sv =====
package sdtq_pkg;

   localparam int DEPTH = 16;
   localparam int TAG_WIDTH = 8;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int TIME_W = 63;
   localparam int HANDLE_W = 4;
   localparam int ENTRY_W = TIME_W + TAG_WIDTH + HANDLE_W;

   typedef enum logic [1:0] {
      CMD_ADD_ABS = 2'd0,
      CMD_ADD_REL = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_EXPIRE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ADDED    = 3'd0,
      KIND_REMOVED  = 3'd1,
      KIND_NOTFOUND = 3'd2,
      KIND_FULL     = 3'd3,
      KIND_EXPIRED  = 3'd4,
      KIND_NONEDUE  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [TIME_W-1:0]   now_time;
      logic [TIME_W-1:0]   deadline_or_interval;
      logic [7:0]          callback_tag;
      logic [HANDLE_W-1:0] timer_handle;
   } req_type;

   typedef struct packed {
      logic [2:0]          kind;
      logic [HANDLE_W-1:0] result_handle;
      logic [7:0]          result_tag;
      logic [TIME_W-1:0]   next_deadline;
      logic                armed;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]    deadline;
      logic [TAG_WIDTH-1:0] tag;
      logic [HANDLE_W-1:0]  handle;
   } entry_type;

endpackage

// ===== sv/sdtq_if.sv =====
interface sdtq_req_if (input logic clock);
   logic               valid;
   logic               ready;
   sdtq_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface sdtq_rsp_if (input logic clock);
   logic               valid;
   logic               ready;
   sdtq_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/sdtq_ram.sv =====
module sdtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/sorted_deadline_timer_queue.sv =====
// Channel | Dir | Signals                         | Transaction
// req     | in  | req.valid/ready/payload         | one timer command
// rsp     | out | rsp.valid/ready/payload         | one result, last on final
//
// Sorted entries live in one RAM (one read, one write a cycle, registered read).
// Add/remove walk the RAM one entry at a time, ST_SCAN reading and ST_MOVE shifting; full/not found skip the walk.
// Expire: ST_HEAD checks entry 0; each due entry is dropped by a walk and reported, then ST_WAIT rereads entry 0.
// Reset clears count and handle bitmap; RAM data is used only below count.
// A result waits in the output register; no command is accepted and no further result is loaded until it is taken.
module sorted_deadline_timer_queue (
   input logic       clock,
   input logic       reset,
   sdtq_req_if.sink  req,
   sdtq_rsp_if.source rsp
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_MOVE  = 6'b000100,
      ST_HEAD  = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   localparam logic [sdtq_pkg::TIME_W-1:0] TMAX = '1;

   state_type                        state_ff, state_in;
   sdtq_pkg::req_type                cur_ff, cur_in;
   logic [sdtq_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [sdtq_pkg::DEPTH-1:0]       used_ff, used_in;
   logic [sdtq_pkg::CNT_W-1:0]       pos_ff, pos_in;
   logic                             ins_ff, ins_in;     // insert walk vs drop walk
   sdtq_pkg::entry_type              carry_ff, carry_in; // entry moving up on insert
   logic                             any_ff, any_in;
   logic [sdtq_pkg::HANDLE_W-1:0]    hnd_ff, hnd_in;
   logic [7:0]                       tag_ff, tag_in;
   logic [2:0]                       kind_ff, kind_in;
   logic                             rvalid_ff, rvalid_in;
   sdtq_pkg::rsp_type                rsp_ff, rsp_in;
   logic [sdtq_pkg::TIME_W-1:0]      head_ff, head_in;

   logic                             wr_en;
   logic [sdtq_pkg::IDX_W-1:0]       wr_addr, rd_addr;
   sdtq_pkg::entry_type              wr_data, rd_data;

   sdtq_ram #(.WIDTH(sdtq_pkg::ENTRY_W), .DEPTH(sdtq_pkg::DEPTH)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data(wr_data), .rd_addr, .rd_data(rd_data)
   );

   logic [sdtq_pkg::TIME_W:0] sum;
   logic [sdtq_pkg::TIME_W-1:0] add_dl;
   logic [sdtq_pkg::HANDLE_W-1:0] free_h;
   logic free_ok;
   logic rsp_free;

   assign sum = {1'b0, req.payload.now_time} + {1'b0, req.payload.deadline_or_interval};
   // relative add saturates at the largest time
   assign add_dl = (req.payload.cmd == sdtq_pkg::CMD_ADD_REL) ?
                   (sum[sdtq_pkg::TIME_W] ? TMAX : sum[sdtq_pkg::TIME_W-1:0]) :
                   req.payload.deadline_or_interval;
   assign rsp_free = !rvalid_ff || rsp.ready;

   always_comb begin
      free_h = '0;
      free_ok = 1'b0;
      for (int i = sdtq_pkg::DEPTH - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_h = sdtq_pkg::HANDLE_W'(i);
            free_ok = 1'b1;
         end
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && rsp_free;
   assign rsp.valid = rvalid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      used_in = used_ff;
      pos_in = pos_ff;
      ins_in = ins_ff;
      carry_in = carry_ff;
      any_in = any_ff;
      hnd_in = hnd_ff;
      tag_in = tag_ff;
      kind_in = kind_ff;
      head_in = head_ff;
      rvalid_in = rvalid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = pos_ff[sdtq_pkg::IDX_W-1:0];
      wr_data = carry_ff;
      rd_addr = pos_ff[sdtq_pkg::IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req.valid && req.ready) begin
               cur_in = req.payload;
               pos_in = '0;
               any_in = 1'b0;
               hnd_in = req.payload.timer_handle;
               tag_in = '0;
               if (req.payload.cmd == sdtq_pkg::CMD_EXPIRE) begin
                  state_in = ST_HEAD;
               end else if (req.payload.cmd == sdtq_pkg::CMD_REMOVE) begin
                  if (used_ff[req.payload.timer_handle]) begin
                     ins_in = 1'b0;
                     state_in = ST_SCAN;
                  end else begin
                     kind_in = sdtq_pkg::KIND_NOTFOUND;
                     state_in = ST_EMIT;
                  end
               end else if (cnt_ff >= sdtq_pkg::CNT_W'(sdtq_pkg::DEPTH) || !free_ok) begin
                  kind_in = sdtq_pkg::KIND_FULL;
                  hnd_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  ins_in = 1'b1;
                  hnd_in = free_h;
                  carry_in.deadline = add_dl;
                  carry_in.tag = req.payload.callback_tag[sdtq_pkg::TAG_WIDTH-1:0];
                  carry_in.handle = free_h;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue read of pos; data arrives in ST_MOVE
            rd_addr = pos_ff[sdtq_pkg::IDX_W-1:0];
            if (pos_ff >= cnt_ff) begin
               if (ins_ff) begin
                  wr_en = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  used_in[hnd_ff] = 1'b1;
                  head_in = (cnt_ff == '0 || pos_ff == '0) ? carry_ff.deadline : head_ff;
                  kind_in = sdtq_pkg::KIND_ADDED;
               end else begin
                  // drop walk finished
                  cnt_in = cnt_ff - 1'b1;
                  used_in[hnd_ff] = 1'b0;
                  kind_in = (cur_ff.cmd == sdtq_pkg::CMD_EXPIRE) ?
                     sdtq_pkg::KIND_EXPIRED : sdtq_pkg::KIND_REMOVED;
               end
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (ins_ff) begin
               if (any_ff || rd_data.deadline >= carry_ff.deadline) begin
                  // place carry here, old entry moves up
                  wr_en = 1'b1;
                  if (pos_ff == '0) head_in = carry_ff.deadline;
                  carry_in = rd_data;
                  any_in = 1'b1;
               end
               pos_in = pos_ff + 1'b1;
            end else begin
               if (any_ff) begin
                  wr_en = 1'b1;
                  wr_addr = sdtq_pkg::IDX_W'(pos_ff - 1'b1);
                  wr_data = rd_data;
                  if (pos_ff == sdtq_pkg::CNT_W'(1)) head_in = rd_data.deadline;
               end else if (rd_data.handle == hnd_ff) begin
                  any_in = 1'b1;
                  tag_in = 8'(rd_data.tag);
               end
               pos_in = pos_ff + 1'b1;
            end
            state_in = ST_SCAN;
         end
         ST_HEAD: begin
            // rd_data holds entry 0 when entered from ST_IDLE or ST_WAIT (both read address 0)
            if (cnt_ff != '0 && rd_data.deadline <= cur_ff.now_time) begin
               hnd_in = rd_data.handle;
               ins_in = 1'b0;
               pos_in = '0;
               any_in = 1'b0;
               state_in = ST_SCAN;
            end else if (kind_ff == sdtq_pkg::KIND_EXPIRED && any_ff) begin
               state_in = ST_IDLE;
            end else begin
               kind_in = sdtq_pkg::KIND_NONEDUE;
               hnd_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rd_addr = '0;
            if (rsp_free) begin
               rvalid_in = 1'b1;
               rsp_in.kind = kind_ff;
               rsp_in.result_handle = hnd_ff;
               rsp_in.result_tag = (kind_ff == sdtq_pkg::KIND_EXPIRED) ? tag_ff : '0;
               rsp_in.armed = (cnt_ff != '0);
               rsp_in.next_deadline = (cnt_ff != '0) ? head_ff : '0;
               rsp_in.last = 1'b1;
               state_in = ST_IDLE;
               if (kind_ff == sdtq_pkg::KIND_EXPIRED) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            // entry 0 is read now; decide in ST_HEAD whether more are due
            rd_addr = '0;
            kind_in = sdtq_pkg::KIND_EXPIRED;
            any_in = 1'b1;
            state_in = ST_HEAD;
         end
         default: state_in = ST_IDLE;
      endcase

      // expire: a result is last only if nothing further is due after it
      if (state_ff == ST_EMIT && rsp_free && kind_ff == sdtq_pkg::KIND_EXPIRED) begin
         rvalid_in = 1'b0;
      end
      if (state_ff == ST_HEAD && kind_ff == sdtq_pkg::KIND_EXPIRED && any_ff && rsp_free) begin
         rvalid_in = 1'b1;
         rsp_in.last = !(cnt_ff != '0 && rd_data.deadline <= cur_ff.now_time);
      end else if (state_ff == ST_HEAD && kind_ff == sdtq_pkg::KIND_EXPIRED && any_ff) begin
         state_in = ST_HEAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         used_ff <= '0;
         rvalid_ff <= 1'b0;
         kind_ff <= sdtq_pkg::KIND_ADDED;
         any_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         used_ff <= used_in;
         rvalid_ff <= rvalid_in;
         kind_ff <= kind_in;
         any_ff <= any_in;
      end
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      ins_ff <= ins_in;
      carry_ff <= carry_in;
      hnd_ff <= hnd_in;
      tag_ff <= tag_in;
      rsp_ff <= rsp_in;
      head_ff <= head_in;
   end
endmodule

// ===== sv/sdtq_checker.sv =====
module sdtq_assertions (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input sdtq_pkg::rsp_type rsp_payload
);
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload)) else $error("rsp changed in stall");
   a_armed_dl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.armed |-> rsp_payload.next_deadline == '0)
      else $error("deadline without armed");
   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != sdtq_pkg::KIND_EXPIRED |-> rsp_payload.result_tag == '0)
      else $error("tag on non-expire");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.kind == sdtq_pkg::KIND_ADDED ||
      rsp_payload.kind == sdtq_pkg::KIND_FULL) |-> rsp_payload.last)
      else $error("add gave more than one result");
   // one command in flight at a time
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req accepted while busy");
endmodule

bind sorted_deadline_timer_queue sdtq_assertions u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
